// File: rtl/wpps_pkg.sv
// Shared constants for the wheel position PID servo.
`timescale 1ns / 1ps
package wpps_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_I   = 3'd1;
    localparam logic [2:0] CFG_GAIN_D   = 3'd2;
    localparam logic [2:0] CFG_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_WINDOW   = 3'd4;

    localparam int GAIN_W   = 32;
    localparam int LIMIT_W  = 10;
    localparam int WINDOW_W = 16;
    localparam int FRAC_W   = 24;
    localparam int TERM_W   = 16;

    localparam logic [GAIN_W-1:0]   GAIN_P_RST = 32'd41943040;
    localparam logic [GAIN_W-1:0]   GAIN_I_RST = 32'd2;
    localparam logic [GAIN_W-1:0]   GAIN_D_RST = 32'd33554432;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 10'd55;
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd4;

    typedef logic signed [TERM_W-1:0] t_term;

endpackage

// File: rtl/wpps_term.sv
// One PID term: registered Q8.24 multiply, then truncation and int16 saturation.
`timescale 1ns / 1ps
module wpps_term (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [wpps_pkg::GAIN_W-1:0]        i_gain,
    input  logic signed [32:0]                 i_operand,
    output wpps_pkg::t_term                    o_term
);

    logic [32:0] w_mag33;
    logic [31:0] w_mag;
    logic [63:0] r_prod;
    logic        r_neg;
    logic [39:0] w_q;

    // operand magnitude never exceeds 2^32 - 1
    assign w_mag33 = i_operand[32] ? (33'd0 - i_operand) : i_operand;
    assign w_mag   = w_mag33[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_mag * i_gain;
            r_neg  <= i_operand[32];
        end
    end

    assign w_q = r_prod[63:wpps_pkg::FRAC_W];

    always_comb begin
        if (r_neg) begin
            if (w_q >= 40'd32768) begin
                o_term = 16'sh8000;
            end else begin
                o_term = wpps_pkg::t_term'(16'd0 - w_q[15:0]);
            end
        end else begin
            if (w_q > 40'd32767) begin
                o_term = 16'sh7FFF;
            end else begin
                o_term = wpps_pkg::t_term'(w_q[15:0]);
            end
        end
    end

endmodule

// File: rtl/wheel_position_pid_servo.sv
// Top level of the wheel position PID servo.
`timescale 1ns / 1ps
// Position servo for one wheel.
// Input stream (s_axis): tuser carries the item kind (edge, tick, start);
// tdata carries the edge direction and, for a start, the signed target.
// Encoder edges step the position count, a start loads the target and
// clears position, integral and previous error; each control tick yields
// one result on the output stream (m_axis): duty, reverse and moving.
// Configuration (gains, duty limit, settle window) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data while no tick is in flight.
// Throughput: one item per cycle while s_axis_tready is high. A tick
// accepted at the input loads the error stage, then the multiply stage,
// then the sum and clamp into the output register behind m_axis_tvalid.
// State updates happen at the accepting edge, so edges and starts can
// follow a tick back to back.
// Reset restores the default gains, limit 55 and window 4 and clears the
// position, target, integral and previous error; the pipeline empties.
// When the receiver stalls, the pipeline stages fill up; s_axis_tready
// drops only once all three stages hold a waiting result.
module wheel_position_pid_servo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [0] edge_forward, [32:1] target_counts, zero pad
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] duty, [10] reverse, [11] moving, zero pad
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // configuration
    logic [wpps_pkg::GAIN_W-1:0]   r_gain_p, r_gain_i, r_gain_d;
    logic [wpps_pkg::LIMIT_W-1:0]  r_limit;
    logic [wpps_pkg::WINDOW_W-1:0] r_window;

    // servo state
    logic signed [31:0] r_pos, r_target, r_integ, r_prev;
    logic signed [31:0] n_pos, n_target, n_integ, n_prev;

    // pipeline
    logic               r_v1, r_v2, r_vo;
    logic signed [31:0] r1_e, r1_integ;
    logic signed [32:0] r1_delta;
    logic               r2_moving;
    logic [9:0]         r_duty;
    logic               r_reverse, r_moving;

    logic ld_o, ld_2, ld_1, w_acc, w_tick;
    logic [1:0]         w_cmd;
    logic               w_fwd;
    logic signed [31:0] w_tc;
    logic signed [32:0] w_err33, w_int33, w_delta;
    logic signed [31:0] w_e, w_integ;
    logic [32:0]        w_emag;
    wpps_pkg::t_term    w_tp, w_ti, w_td;
    logic signed [17:0] w_sum, w_lim, w_clamp, w_cmag;

    assign ld_o = !r_vo || m_axis_tready;
    assign ld_2 = !r_v2 || ld_o;
    assign ld_1 = !r_v1 || ld_2;

    assign s_axis_tready = ld_1;
    assign w_acc  = s_axis_tvalid && ld_1;
    assign w_cmd  = s_axis_tuser;
    assign w_fwd  = s_axis_tdata[0];
    assign w_tc   = s_axis_tdata[32:1];
    assign w_tick = w_acc && (w_cmd == wpps_pkg::CMD_TICK);

    // error and integral, both saturated to int32
    always_comb begin
        w_err33 = {r_target[31], r_target} - {r_pos[31], r_pos};
        if (w_err33[32] != w_err33[31]) begin
            w_e = w_err33[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            w_e = w_err33[31:0];
        end
        w_int33 = {r_integ[31], r_integ} + {w_e[31], w_e};
        if (w_int33[32] != w_int33[31]) begin
            w_integ = w_int33[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            w_integ = w_int33[31:0];
        end
        w_delta = {w_e[31], w_e} - {r_prev[31], r_prev};
    end

    always_comb begin
        n_pos    = r_pos;
        n_target = r_target;
        n_integ  = r_integ;
        n_prev   = r_prev;
        if (w_acc) begin
            case (w_cmd)
                wpps_pkg::CMD_EDGE: begin
                    n_pos = w_fwd ? r_pos + 32'sd1 : r_pos - 32'sd1;
                end
                wpps_pkg::CMD_TICK: begin
                    n_integ = w_integ;
                    n_prev  = w_e;
                end
                wpps_pkg::CMD_START: begin
                    n_target = w_tc;
                    n_pos    = '0;
                    n_integ  = '0;
                    n_prev   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= wpps_pkg::GAIN_P_RST;
            r_gain_i <= wpps_pkg::GAIN_I_RST;
            r_gain_d <= wpps_pkg::GAIN_D_RST;
            r_limit  <= wpps_pkg::LIMIT_RST;
            r_window <= wpps_pkg::WINDOW_RST;
            r_pos    <= '0;
            r_target <= '0;
            r_integ  <= '0;
            r_prev   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_vo     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wpps_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data;
                    wpps_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data;
                    wpps_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data;
                    wpps_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[wpps_pkg::LIMIT_W-1:0];
                    wpps_pkg::CFG_WINDOW: r_window <= i_cfg_data[wpps_pkg::WINDOW_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_pos    <= n_pos;
            r_target <= n_target;
            r_integ  <= n_integ;
            r_prev   <= n_prev;
            if (ld_1) r_v1 <= w_tick;
            if (ld_2) r_v2 <= r_v1;
            if (ld_o) r_vo <= r_v2;
        end
    end

    // error stage payload
    always_ff @(posedge i_clk) begin
        if (ld_1) begin
            r1_e     <= w_e;
            r1_integ <= w_integ;
            r1_delta <= w_delta;
        end
    end

    // multiply stage
    assign w_emag = r1_e[31] ? (33'd0 - {r1_e[31], r1_e}) : {1'b0, r1_e};

    always_ff @(posedge i_clk) begin
        if (ld_2) begin
            r2_moving <= (w_emag >= {17'd0, r_window});
        end
    end

    wpps_term u_term_p (
        .i_clk     (i_clk),
        .i_en      (ld_2),
        .i_gain    (r_gain_p),
        .i_operand ({r1_e[31], r1_e}),
        .o_term    (w_tp)
    );

    wpps_term u_term_i (
        .i_clk     (i_clk),
        .i_en      (ld_2),
        .i_gain    (r_gain_i),
        .i_operand ({r1_integ[31], r1_integ}),
        .o_term    (w_ti)
    );

    wpps_term u_term_d (
        .i_clk     (i_clk),
        .i_en      (ld_2),
        .i_gain    (r_gain_d),
        .i_operand (r1_delta),
        .o_term    (w_td)
    );

    // sum without wrap, then clamp to the duty limit
    always_comb begin
        w_sum = 18'(w_tp) + 18'(w_ti) + 18'(w_td);
        w_lim = {8'd0, r_limit};
        if (w_sum > w_lim) begin
            w_clamp = w_lim;
        end else if (w_sum < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = w_sum;
        end
        w_cmag = w_clamp[17] ? -w_clamp : w_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (ld_o) begin
            r_duty    <= w_cmag[9:0];
            r_reverse <= w_clamp[17];
            r_moving  <= r2_moving;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {4'd0, r_moving, r_reverse, r_duty};

endmodule

// File: bench/tb_wheel_position_pid_servo.sv
// Testbench for the wheel position PID servo: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_wheel_position_pid_servo;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 100;
    localparam int         SETTLE      = 4;
    localparam int         PHASE_ITEMS = 230;
    localparam longint     I32_HI      = 64'sd2147483647;
    localparam longint     I32_LO      = -64'sd2147483648;

    typedef struct packed {
        logic [9:0] duty;
        logic       rev;
        logic       mov;
    } t_drive;

    typedef struct packed {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic [1:0]  kind;
        logic        fwd;
        logic [31:0] tgt;
        bit          typed;
        t_drive      want;
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    // servo state and register copies
    int          cur_pos;
    int          cur_target;
    int          err_sum;
    int          last_err;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [9:0]  lim_reg;
    logic [15:0] win_reg;

    t_drive      pending_drive[$];
    t_step       plan[$];
    int          mismatch_count;
    bit          hold_req;
    bit          calm;

    wheel_position_pid_servo i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int clip32(input longint v);
        if (v > I32_HI) return 32'sh7fff_ffff;
        if (v < I32_LO) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Q8.24 gain times operand, truncate toward zero, saturate to int16
    function automatic int gain_term(input logic [31:0] g, input longint x);
        logic [63:0] mag;
        logic [95:0] prod;
        logic [95:0] q;
        mag  = (x < 0) ? -x : x;
        prod = {32'd0, mag};
        prod = prod * g;
        q    = prod >> wpps_pkg::FRAC_W;
        if (x < 0) begin
            if (q > 96'd32768) return -32768;
            return -int'(q[31:0]);
        end
        if (q > 96'd32767) return 32767;
        return int'(q[31:0]);
    endfunction

    task automatic servo_predict(input logic [1:0] kind, input logic fwd,
                                 input logic [31:0] tgt,
                                 output bit has_res, output t_drive res);
        longint err;
        longint delta;
        longint sum;
        longint lim;
        longint emag;
        int     e;
        has_res = 1'b0;
        res     = '0;
        case (kind)
            wpps_pkg::CMD_EDGE: cur_pos = fwd ? cur_pos + 1 : cur_pos - 1;
            wpps_pkg::CMD_START: begin
                cur_target = tgt;
                cur_pos    = 0;
                err_sum    = 0;
                last_err   = 0;
            end
            wpps_pkg::CMD_TICK: begin
                err      = longint'(cur_target) - longint'(cur_pos);
                e        = clip32(err);
                err_sum  = clip32(longint'(err_sum) + longint'(e));
                delta    = longint'(e) - longint'(last_err);
                last_err = e;
                sum = longint'(gain_term(kp, e)) + longint'(gain_term(ki, err_sum))
                    + longint'(gain_term(kd, delta));
                lim = longint'(lim_reg);
                if (sum > lim) sum = lim;
                if (sum < -lim) sum = -lim;
                emag     = (e < 0) ? -longint'(e) : longint'(e);
                res.rev  = (sum < 0);
                if (sum < 0) sum = -sum;
                res.duty = sum[9:0];
                res.mov  = (emag >= longint'(win_reg));
                has_res  = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic send_item(input logic [1:0] kind, input logic fwd, input logic [31:0] tgt,
                             input bit typed, input t_drive want);
        bit     has_res;
        t_drive res;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, tgt, fwd};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        servo_predict(kind, fwd, tgt, has_res, res);
        if (has_res) pending_drive.push_back(typed ? want : res);
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // stop sending, wait for every result, then let the pipeline settle
    task automatic drain_results();
        idle_sender(1);
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            wpps_pkg::CFG_GAIN_P: kp      = val;
            wpps_pkg::CFG_GAIN_I: ki      = val;
            wpps_pkg::CFG_GAIN_D: kd      = val;
            wpps_pkg::CFG_LIMIT:  lim_reg = val[wpps_pkg::LIMIT_W-1:0];
            wpps_pkg::CFG_WINDOW: win_reg = val[wpps_pkg::WINDOW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [1:0] kind, input logic fwd, input logic [31:0] tgt);
        t_step s;
        s      = '0;
        s.kind = kind;
        s.fwd  = fwd;
        s.tgt  = tgt;
        plan.push_back(s);
    endtask

    task automatic add_checked(input logic [1:0] kind, input logic [31:0] tgt,
                               input int duty, input bit rev, input bit mov);
        t_step s;
        s       = '0;
        s.kind  = kind;
        s.tgt   = tgt;
        s.typed = 1'b1;
        s.want  = '{duty: duty[9:0], rev: rev, mov: mov};
        plan.push_back(s);
    endtask

    task automatic add_cfg(input logic [2:0] idx, input logic [31:0] val);
        t_step s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        plan.push_back(s);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin : rx_side
        int stall_left;
        int k;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
            end
        end
    end

    always @(posedge i_clk) begin : drive_check
        t_drive want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_drive.size() == 0) begin
                note_mismatch("result with nothing pending", m_axis_tdata[9:0], 0);
            end else begin
                want = pending_drive.pop_front();
                if (m_axis_tdata[9:0] !== want.duty)
                    note_mismatch("duty", m_axis_tdata[9:0], want.duty);
                if (m_axis_tdata[10] !== want.rev)
                    note_mismatch("reverse", m_axis_tdata[10], want.rev);
                if (m_axis_tdata[11] !== want.mov)
                    note_mismatch("moving", m_axis_tdata[11], want.mov);
            end
        end
    end

    initial begin : watchdog
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        t_drive      none;
        logic [31:0] g_p;
        logic [31:0] g_i;
        logic [31:0] g_d;
        logic [31:0] lim;
        logic [31:0] win;
        logic [1:0]  kind;
        logic        fwd;
        logic [31:0] tgt;
        int          ph;
        int          done;
        int          pick;
        int          k;

        none           = '0;
        mismatch_count = 0;
        hold_req       = 1'b0;
        calm           = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = wpps_pkg::CMD_EDGE;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = wpps_pkg::CFG_GAIN_P;
        i_cfg_data     = '0;
        kp             = wpps_pkg::GAIN_P_RST;
        ki             = wpps_pkg::GAIN_I_RST;
        kd             = wpps_pkg::GAIN_D_RST;
        lim_reg        = wpps_pkg::LIMIT_RST;
        win_reg        = wpps_pkg::WINDOW_RST;
        cur_pos        = 0;
        cur_target     = 0;
        err_sum        = 0;
        last_err       = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        add_checked(wpps_pkg::CMD_TICK, 32'd0, 0, 1'b0, 1'b0);
        add_item(CMD_UNUSED, 1'b1, 32'hffff_ffff);
        add_checked(wpps_pkg::CMD_TICK, 32'hffff_ffff, 0, 1'b0, 1'b0);
        add_item(wpps_pkg::CMD_EDGE, 1'b0, 32'd0);
        add_item(wpps_pkg::CMD_TICK, 1'b1, 32'h5555_5555);
        add_item(wpps_pkg::CMD_EDGE, 1'b1, 32'd0);
        add_item(wpps_pkg::CMD_EDGE, 1'b1, 32'd0);
        add_item(wpps_pkg::CMD_TICK, 1'b0, 32'haaaa_aaaa);
        // largest target: the P and D terms saturate positive
        add_item(wpps_pkg::CMD_START, 1'b0, 32'h7fff_ffff);
        add_checked(wpps_pkg::CMD_TICK, 32'd0, int'(wpps_pkg::LIMIT_RST), 1'b0, 1'b1);
        add_item(wpps_pkg::CMD_TICK, 1'b0, 32'd0);
        add_item(wpps_pkg::CMD_TICK, 1'b0, 32'd0);
        // most negative target one count behind: error clips at the low end
        add_item(wpps_pkg::CMD_START, 1'b1, 32'h8000_0000);
        add_item(wpps_pkg::CMD_EDGE, 1'b1, 32'd0);
        add_checked(wpps_pkg::CMD_TICK, 32'd0, int'(wpps_pkg::LIMIT_RST), 1'b1, 1'b1);
        add_item(wpps_pkg::CMD_TICK, 1'b0, 32'd0);
        // zero limit and zero window
        add_cfg(wpps_pkg::CFG_LIMIT, 32'd0);
        add_cfg(wpps_pkg::CFG_WINDOW, 32'd0);
        add_item(wpps_pkg::CMD_START, 1'b0, 32'd1000);
        add_checked(wpps_pkg::CMD_TICK, 32'd0, 0, 1'b0, 1'b1);
        add_item(wpps_pkg::CMD_START, 1'b0, 32'd0);
        add_checked(wpps_pkg::CMD_TICK, 32'd0, 0, 1'b0, 1'b1);
        // largest gains, limit and window
        add_cfg(wpps_pkg::CFG_GAIN_P, 32'hffff_ffff);
        add_cfg(wpps_pkg::CFG_GAIN_I, 32'hffff_ffff);
        add_cfg(wpps_pkg::CFG_GAIN_D, 32'hffff_ffff);
        add_cfg(wpps_pkg::CFG_LIMIT, 32'd1023);
        add_cfg(wpps_pkg::CFG_WINDOW, 32'hffff);
        add_item(wpps_pkg::CMD_START, 1'b0, -32'sd5);
        add_checked(wpps_pkg::CMD_TICK, 32'd0, 1023, 1'b1, 1'b0);
        add_item(wpps_pkg::CMD_TICK, 1'b0, 32'd0);
        add_cfg(wpps_pkg::CFG_GAIN_P, 32'd0);
        add_cfg(wpps_pkg::CFG_GAIN_I, 32'd0);
        add_cfg(wpps_pkg::CFG_GAIN_D, 32'd0);
        add_checked(wpps_pkg::CMD_TICK, 32'd0, 0, 1'b0, 1'b0);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain_results();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_item(plan[k].kind, plan[k].fwd, plan[k].tgt, plan[k].typed, plan[k].want);
            end
        end

        // random phases, each under its own register setting
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    g_p = wpps_pkg::GAIN_P_RST;
                    g_i = wpps_pkg::GAIN_I_RST;
                    g_d = wpps_pkg::GAIN_D_RST;
                    lim = {22'd0, wpps_pkg::LIMIT_RST};
                    win = {16'd0, wpps_pkg::WINDOW_RST};
                end
                1: begin
                    g_p = $urandom_range(0, 32'h0fff_ffff);
                    g_i = $urandom_range(0, 32'h000f_ffff);
                    g_d = $urandom_range(0, 32'h0fff_ffff);
                    lim = $urandom_range(1, 1023);
                    win = $urandom_range(0, 64);
                end
                2: begin
                    g_p = 32'hffff_ffff;
                    g_i = 32'd0;
                    g_d = 32'd0;
                    lim = 32'd1023;
                    win = 32'hffff;
                end
                3: begin
                    g_p = $urandom;
                    g_i = $urandom;
                    g_d = $urandom;
                    lim = $urandom_range(0, 1023);
                    win = $urandom_range(0, 65535);
                end
                default: begin
                    g_p = $urandom_range(32'h0040_0000, 32'h0400_0000);
                    g_i = $urandom_range(0, 32'h0001_0000);
                    g_d = $urandom_range(0, 32'h0200_0000);
                    lim = $urandom_range(100, 400);
                    win = $urandom_range(0, 8);
                end
            endcase
            drain_results();
            write_reg(wpps_pkg::CFG_GAIN_P, g_p);
            write_reg(wpps_pkg::CFG_GAIN_I, g_i);
            write_reg(wpps_pkg::CFG_GAIN_D, g_d);
            write_reg(wpps_pkg::CFG_LIMIT, lim);
            write_reg(wpps_pkg::CFG_WINDOW, win);
            calm = (ph == 4);

            if (ph == 1) begin
                // long receiver hold-off while ticks keep coming back to back
                hold_req = 1'b1;
                for (k = 0; k < 30; k++)
                    send_item(wpps_pkg::CMD_TICK, 1'($urandom_range(0, 1)), $urandom,
                              1'b0, none);
            end

            done = 0;
            while (done < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                tgt  = $urandom;
                fwd  = 1'($urandom_range(0, 1));
                if (pick < 8) begin
                    kind = wpps_pkg::CMD_START;
                    pick = $urandom_range(0, 19);
                    if (pick < 12)      tgt = $urandom_range(0, 600) - 300;
                    else if (pick < 17) tgt = $urandom_range(0, 140000) - 70000;
                end else if (pick < 12) begin
                    kind = CMD_UNUSED;
                end else if (pick < 64) begin
                    kind = wpps_pkg::CMD_EDGE;
                    // mostly step toward the target, as a real wheel would
                    if ($urandom_range(0, 3) != 0) fwd = (cur_pos < cur_target);
                end else begin
                    kind = wpps_pkg::CMD_TICK;
                end
                send_item(kind, fwd, tgt, 1'b0, none);
                if (kind != CMD_UNUSED) done++;
                if (!calm && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 12));
                if (!calm && $urandom_range(0, 99) == 0) drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
